FILE: sv/hcp_pkg.sv
// Shared types, character constants and helper functions for the hex command
// parser bus bridge. No dependencies; every other file imports this package.
package hcp_pkg;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_RESET  = 2'd1,
        CMD_SINGLE = 2'd2,
        CMD_PAGE   = 2'd3
    } cmd_t;

    // Parser states: idle, after each first letter, then one state per
    // expected address digit of a single read or a page read.
    typedef enum logic [3:0] {
        ST_IDLE = 4'd0,
        ST_X    = 4'd1,
        ST_S    = 4'd2,
        ST_P    = 4'd3,
        ST_SR0  = 4'd4,
        ST_SR1  = 4'd5,
        ST_SR2  = 4'd6,
        ST_SR3  = 4'd7,
        ST_SR4  = 4'd8,
        ST_SR5  = 4'd9,
        ST_SR6  = 4'd10,
        ST_SR7  = 4'd11,
        ST_PR0  = 4'd12,
        ST_PR1  = 4'd13,
        ST_PR2  = 4'd14,
        ST_PR3  = 4'd15
    } parse_state_t;

    localparam logic [7:0] CH_X  = 8'h58;
    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_P  = 8'h50;
    localparam logic [7:0] CH_R  = 8'h52;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;

    localparam logic [1:0] BEAT_FIRST = 2'd0;
    localparam logic [1:0] BEAT_LAST  = 2'd3;

    // One pending piece of output work handed from the parser to the emitter.
    typedef struct packed {
        logic        is_hex;
        cmd_t        cmd;
        logic [31:0] addr;
        logic        lvl;
        logic        has_char;
        logic [7:0]  tx_char;
        logic [15:0] data;
    } job_t;

    // Any byte that is not a hex digit counts as zero.
    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c inside {[CH_0:CH_9]}) begin
            d = 4'(c - CH_0);
        end
        else if (c inside {[CH_UA:CH_UF]}) begin
            d = 4'(c - CH_UA + 8'd10);
        end
        else if (c inside {[CH_LA:CH_LF]}) begin
            d = 4'(c - CH_LA + 8'd10);
        end
        return d;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = CH_0 + {4'd0, nib};
        end
        else begin
            ch = CH_UA + {4'd0, nib} - 8'd10;
        end
        return ch;
    endfunction

endpackage

FILE: sv/hex_command_parser_bus_bridge_unit.sv
// Hex command parser bus bridge, top level.
// A word accepted at the input is registered, then parsed into the result register.
// Throughput: one command byte per cycle while the result register can take a job;
// a read-data word holds the result register for four hex character words, one
// per cycle while result_stall is low, set by the beat counter.
// Reset (rst_n, asynchronous, active low): parser idle, address zero, no words held.
module hex_command_parser_bus_bridge_unit
    import hcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        func,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] read_data,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  cmd,
    output logic [31:0] bus_address,
    output logic        reset_level,
    output logic        has_char,
    output logic [7:0]  tx_char,
    output logic        last
);

    // The input register decouples the upstream handshake from the parser. It
    // drains whenever the result register is empty or is sending its final word,
    // so a new word is taken while a finished result still waits downstream.
    logic        in_vld_reg;
    logic        in_vld_next;
    logic        func_reg;
    logic [7:0]  byte_reg;
    logic [15:0] data_reg;
    logic        in_accept;
    logic        advance;
    logic        job_free;
    logic        job_valid;
    job_t        job;

    assign advance    = in_vld_reg && job_free;
    assign item_stall = in_vld_reg && !advance;
    assign in_accept  = item_valid && !item_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_accept) begin
            in_vld_next = 1'b1;
        end
        else if (advance) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end
        else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            func_reg <= func;
            byte_reg <= rx_byte;
            data_reg <= read_data;
        end
    end

    // The parser steps once per word taken out of the input register; command bytes
    // that complete no command update the state and produce no job.
    hcp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .func      (func_reg),
        .rx_byte   (byte_reg),
        .read_data (data_reg),
        .job_valid (job_valid),
        .job       (job)
    );

    hcp_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && job_valid),
        .job_in       (job),
        .job_free     (job_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .bus_address  (bus_address),
        .reset_level  (reset_level),
        .has_char     (has_char),
        .tx_char      (tx_char),
        .last         (last)
    );

endmodule

FILE: sv/hcp_parser.sv
// Command parser: holds the parse state and address accumulator and turns
// each stepped word into at most one output job. Depends on hcp_pkg.
module hcp_parser
    import hcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        func,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] read_data,
    output logic        job_valid,
    output job_t        job
);

    parse_state_t state_reg;
    parse_state_t state_next;
    logic [31:0]  accum_reg;
    logic [31:0]  accum_next;
    logic [3:0]   digit;
    logic [31:0]  shifted;

    assign digit   = digit_value(rx_byte);
    assign shifted = {accum_reg[27:0], digit};

    always_comb
    begin
        state_next = state_reg;
        accum_next = accum_reg;
        job_valid  = 1'b0;
        job        = '0;
        if (func) begin
            // Read data leaves the parser untouched and always yields four characters.
            job_valid    = 1'b1;
            job.is_hex   = 1'b1;
            job.cmd      = CMD_NONE;
            job.has_char = 1'b1;
            job.data     = read_data;
        end
        else begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (rx_byte == CH_X) begin
                        state_next = ST_X;
                    end
                    else if (rx_byte == CH_S) begin
                        state_next = ST_S;
                    end
                    else if (rx_byte == CH_P) begin
                        state_next = ST_P;
                    end
                end
                ST_X:
                begin
                    state_next   = ST_IDLE;
                    job_valid    = 1'b1;
                    job.cmd      = CMD_RESET;
                    job.lvl      = digit[0];
                    job.has_char = 1'b1;
                    job.tx_char  = CH_0 + {7'd0, digit[0]};
                end
                ST_S:
                begin
                    state_next = (rx_byte == CH_R) ? ST_SR0 : ST_IDLE;
                    accum_next = '0;
                end
                ST_P:
                begin
                    state_next = (rx_byte == CH_R) ? ST_PR0 : ST_IDLE;
                    accum_next = '0;
                end
                ST_SR7:
                begin
                    accum_next = shifted;
                    state_next = ST_IDLE;
                    job_valid  = 1'b1;
                    job.cmd    = CMD_SINGLE;
                    job.addr   = shifted;
                end
                ST_PR3:
                begin
                    accum_next = shifted;
                    state_next = ST_IDLE;
                    job_valid  = 1'b1;
                    job.cmd    = CMD_PAGE;
                    job.addr   = {shifted[15:1], 17'd0};
                end
                default:
                begin
                    accum_next = shifted;
                    state_next = parse_state_t'(4'(state_reg) + 4'd1);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            accum_reg <= '0;
        end
        else if (step) begin
            state_reg <= state_next;
            accum_reg <= accum_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_page_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job.cmd == CMD_PAGE |-> job.addr[16:0] == 17'd0)
        else $error("page read address has low bits set");

    a_data_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        step && func |=> state_reg == $past(state_reg) && accum_reg == $past(accum_reg))
        else $error("read data disturbed the parser");

    a_cmd_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && job_valid && !func |=> state_reg == ST_IDLE)
        else $error("parser not idle after a completed command");
`endif

endmodule

FILE: sv/hcp_emitter.sv
// Result register and beat sequencer: holds one job and presents it as one
// result word, or as four hex character words for read data. Depends on hcp_pkg.
module hcp_emitter
    import hcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  job_t        job_in,
    output logic        job_free,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  cmd,
    output logic [31:0] bus_address,
    output logic        reset_level,
    output logic        has_char,
    output logic [7:0]  tx_char,
    output logic        last
);

    logic       job_vld_reg;
    logic       job_vld_next;
    job_t       job_reg;
    logic [1:0] beat_reg;
    logic [1:0] beat_next;
    logic       out_fire;
    logic       is_last;
    logic [3:0] nib;

    assign out_fire = job_vld_reg && !result_stall;
    assign is_last  = !job_reg.is_hex || (beat_reg == BEAT_LAST);
    assign job_free = !job_vld_reg || (out_fire && is_last);

    always_comb
    begin
        job_vld_next = job_vld_reg;
        beat_next    = beat_reg;
        if (load) begin
            job_vld_next = 1'b1;
            beat_next    = BEAT_FIRST;
        end
        else if (out_fire && is_last) begin
            job_vld_next = 1'b0;
        end
        else if (out_fire) begin
            beat_next = beat_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            job_vld_reg <= 1'b0;
            beat_reg    <= BEAT_FIRST;
        end
        else begin
            job_vld_reg <= job_vld_next;
            beat_reg    <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            job_reg <= job_in;
        end
    end

    // Most significant nibble goes out first.
    always_comb
    begin
        case (beat_reg)
            2'd0:    nib = job_reg.data[15:12];
            2'd1:    nib = job_reg.data[11:8];
            2'd2:    nib = job_reg.data[7:4];
            default: nib = job_reg.data[3:0];
        endcase
    end

    assign result_valid = job_vld_reg;
    assign cmd          = job_reg.cmd;
    assign bus_address  = job_reg.addr;
    assign reset_level  = job_reg.lvl;
    assign has_char     = job_reg.has_char;
    assign tx_char      = job_reg.is_hex ? hex_char(nib) : job_reg.tx_char;
    assign last         = is_last;

`ifndef NO_ASSERTIONS
    a_beat_only_hex: assert property (@(posedge clk) disable iff (!rst_n)
        job_vld_reg && !job_reg.is_hex |-> beat_reg == BEAT_FIRST)
        else $error("beat count moved on a single-word job");

    a_hex_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !is_last |=> result_valid)
        else $error("hex character sequence broken");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> job_free)
        else $error("job loaded over a pending result");
`endif

endmodule
